// File: rtl/core/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_NEG = 3'd4;
    localparam logic [2:0] CMD_EQU = 3'd5;
    localparam logic [2:0] CMD_ABS = 3'd6;

    localparam int QW         = 32;
    localparam int DIV_STAGES = 32;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic        is_div;
        logic        dz;
        logic        eq;
        logic [31:0] pre_re;
        logic [31:0] pre_im;
        logic        pre_ov;
        logic        neg_re;
        logic        neg_im;
        logic        qovf_re;
        logic        qovf_im;
    } cau_side_t;

endpackage

// File: rtl/core/cau_div.sv
// Pipelined restoring divider producing one quotient bit per stage for two lanes.
module cau_div
    import cau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [63:0]      in_den,
    input  logic [63:0]      in_rem_re,
    input  logic [63:0]      in_rem_im,
    input  logic [QW-1:0]    in_nlow_re,
    input  logic [QW-1:0]    in_nlow_im,
    input  cau_side_t        in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QW-1:0]    out_q_re,
    output logic [QW-1:0]    out_q_im,
    output cau_side_t        out_side
);

    logic [DIV_STAGES-1:0] v_reg;
    logic [63:0]           den_reg     [DIV_STAGES];
    logic [63:0]           rem_re_reg  [DIV_STAGES];
    logic [63:0]           rem_im_reg  [DIV_STAGES];
    logic [QW-1:0]         nlow_re_reg [DIV_STAGES];
    logic [QW-1:0]         nlow_im_reg [DIV_STAGES];
    logic [QW-1:0]         q_re_reg    [DIV_STAGES];
    logic [QW-1:0]         q_im_reg    [DIV_STAGES];
    cau_side_t             side_reg    [DIV_STAGES];

    logic [DIV_STAGES-1:0] src_v;
    logic [63:0]           den_next     [DIV_STAGES];
    logic [63:0]           rem_re_next  [DIV_STAGES];
    logic [63:0]           rem_im_next  [DIV_STAGES];
    logic [QW-1:0]         nlow_re_next [DIV_STAGES];
    logic [QW-1:0]         nlow_im_next [DIV_STAGES];
    logic [QW-1:0]         q_re_next    [DIV_STAGES];
    logic [QW-1:0]         q_im_next    [DIV_STAGES];
    cau_side_t             side_next    [DIV_STAGES];

    wire  [DIV_STAGES:0]   rdy;

    assign rdy[DIV_STAGES] = out_ready;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_rdy
            assign rdy[g] = !v_reg[g] || rdy[g+1];
        end
    endgenerate

    always_comb begin
        logic [63:0]   s_rem_re, s_rem_im, s_den;
        logic [QW-1:0] s_nlow_re, s_nlow_im, s_q_re, s_q_im;
        logic [64:0]   t_re, t_im, d_re, d_im;
        logic          ge_re, ge_im;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                src_v[k]     = in_valid;
                s_den        = in_den;
                s_rem_re     = in_rem_re;
                s_rem_im     = in_rem_im;
                s_nlow_re    = in_nlow_re;
                s_nlow_im    = in_nlow_im;
                s_q_re       = '0;
                s_q_im       = '0;
                side_next[k] = in_side;
            end else begin
                src_v[k]     = v_reg[k-1];
                s_den        = den_reg[k-1];
                s_rem_re     = rem_re_reg[k-1];
                s_rem_im     = rem_im_reg[k-1];
                s_nlow_re    = nlow_re_reg[k-1];
                s_nlow_im    = nlow_im_reg[k-1];
                s_q_re       = q_re_reg[k-1];
                s_q_im       = q_im_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            t_re  = {s_rem_re, s_nlow_re[QW-1]};
            t_im  = {s_rem_im, s_nlow_im[QW-1]};
            d_re  = t_re - {1'b0, s_den};
            d_im  = t_im - {1'b0, s_den};
            ge_re = t_re >= {1'b0, s_den};
            ge_im = t_im >= {1'b0, s_den};
            den_next[k]     = s_den;
            rem_re_next[k]  = ge_re ? d_re[63:0] : t_re[63:0];
            rem_im_next[k]  = ge_im ? d_im[63:0] : t_im[63:0];
            nlow_re_next[k] = {s_nlow_re[QW-2:0], 1'b0};
            nlow_im_next[k] = {s_nlow_im[QW-2:0], 1'b0};
            q_re_next[k]    = {s_q_re[QW-2:0], ge_re};
            q_im_next[k]    = {s_q_im[QW-2:0], ge_im};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= src_v[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (rdy[k] && src_v[k]) begin
                den_reg[k]     <= den_next[k];
                rem_re_reg[k]  <= rem_re_next[k];
                rem_im_reg[k]  <= rem_im_next[k];
                nlow_re_reg[k] <= nlow_re_next[k];
                nlow_im_reg[k] <= nlow_im_next[k];
                q_re_reg[k]    <= q_re_next[k];
                q_im_reg[k]    <= q_im_next[k];
                side_reg[k]    <= side_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_q_re  = q_re_reg[DIV_STAGES-1];
    assign out_q_im  = q_im_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// File: rtl/core/complex_arithmetic_unit_top.sv
// Top level of the pipelined complex-number arithmetic unit.
// The unit accepts one transaction per clock unless output back-pressure stalls it, and
// returns results in order: four front stages form the products, sums and divider operands,
// a 32-stage divider pipeline produces one quotient bit per stage, and one output register
// forms the saturated result. Every command travels the full depth. Each stage holds its
// transaction while the next one is full, so empty stages close up during output stalls.
module complex_arithmetic_unit_top
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic signed [31:0] s_a_real,
    input  logic signed [31:0] s_a_imag,
    input  logic signed [31:0] s_b_real,
    input  logic signed [31:0] s_b_imag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_real,
    output logic signed [31:0] m_res_imag,
    output logic               m_is_equal,
    output logic               m_div_zero,
    output logic               m_overflow
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int HW = NW - QW;
    localparam logic [64:0] FMASK = (65'd1 << FRAC_BITS) - 65'd1;

    typedef struct packed {
        logic        ov;
        logic [31:0] val;
    } sat_t;

    function automatic sat_t sat65(input logic [64:0] v);
        sat_t r;
        r.ov  = !((&v[64:31]) || !(|v[64:31]));
        r.val = r.ov ? (v[64] ? Q_MIN : Q_MAX) : v[31:0];
        return r;
    endfunction

    function automatic logic [63:0] trunc_prod(input logic signed [63:0] p);
        logic [63:0] sh;
        logic        adj;
        sh  = p >>> FRAC_BITS;
        adj = p[63] && ((p & FMASK[63:0]) != 64'd0);
        return sh + {63'd0, adj};
    endfunction

    function automatic sat_t div_lane(input logic [QW-1:0] q, input logic neg,
                                      input logic qovf);
        sat_t        r;
        logic [31:0] nq;
        nq = -q;
        if (!neg) begin
            r.ov  = qovf || q[31];
            r.val = r.ov ? Q_MAX : q;
        end else begin
            r.ov  = qovf || (q > Q_MIN);
            r.val = r.ov ? Q_MIN : nq;
        end
        return r;
    endfunction

    logic e_rdy, d_rdy, c_rdy, b_rdy, a_rdy;
    logic div_in_ready, div_out_valid;
    logic [QW-1:0] div_q_re, div_q_im;
    cau_side_t div_side;

    // Stage A: products and simple commands.
    logic               a_v_reg;
    logic [2:0]         a_cmd_reg;
    logic signed [63:0] a_arbr_reg, a_aibi_reg, a_arbi_reg, a_aibr_reg;
    logic signed [63:0] a_brbr_reg, a_bibi_reg;
    logic [31:0]        a_simp_re_reg, a_simp_im_reg;
    logic               a_simp_ov_reg, a_eq_reg, a_dz_reg;

    logic [31:0] simp_re_next, simp_im_next;
    logic        simp_ov_next, eq_next;

    always_comb begin
        logic [64:0] ar, ai, br, bi, vr, vi;
        sat_t        sr, si;
        ar = {{33{s_a_real[31]}}, s_a_real};
        ai = {{33{s_a_imag[31]}}, s_a_imag};
        br = {{33{s_b_real[31]}}, s_b_real};
        bi = {{33{s_b_imag[31]}}, s_b_imag};
        vr = '0;
        vi = '0;
        eq_next = 1'b0;
        unique case (s_command)
            CMD_ADD: begin
                vr = ar + br;
                vi = ai + bi;
            end
            CMD_SUB: begin
                vr = ar - br;
                vi = ai - bi;
            end
            CMD_NEG: begin
                vr = -ar;
                vi = -ai;
            end
            CMD_ABS: begin
                vr = (ar[64] ? -ar : ar) & ~FMASK;
                vi = (ai[64] ? -ai : ai) & ~FMASK;
            end
            CMD_EQU: begin
                eq_next = (s_a_real == s_b_real) && (s_a_imag == s_b_imag);
            end
            default: begin
                vr = '0;
                vi = '0;
            end
        endcase
        sr = sat65(vr);
        si = sat65(vi);
        simp_re_next = sr.val;
        simp_im_next = si.val;
        simp_ov_next = sr.ov || si.ov;
    end

    // Stage B: truncated products, divider numerators and denominator.
    logic               b_v_reg;
    logic [2:0]         b_cmd_reg;
    logic [63:0]        b_tarbr_reg, b_taibi_reg, b_tarbi_reg, b_taibr_reg;
    logic [64:0]        b_num_re_reg, b_num_im_reg;
    logic [63:0]        b_den_reg;
    logic [31:0]        b_simp_re_reg, b_simp_im_reg;
    logic               b_simp_ov_reg, b_eq_reg, b_dz_reg;

    // Stage C: product sums, numerator magnitudes.
    logic               c_v_reg;
    logic [2:0]         c_cmd_reg;
    logic [64:0]        c_msum_re_reg, c_msum_im_reg;
    logic [63:0]        c_mag_re_reg, c_mag_im_reg;
    logic               c_neg_re_reg, c_neg_im_reg;
    logic [63:0]        c_den_reg;
    logic [31:0]        c_simp_re_reg, c_simp_im_reg;
    logic               c_simp_ov_reg, c_eq_reg, c_dz_reg;

    // Stage D: divider operands and result of the non-dividing commands.
    logic               d_v_reg;
    logic [63:0]        d_den_reg, d_rem_re_reg, d_rem_im_reg;
    logic [QW-1:0]      d_nlow_re_reg, d_nlow_im_reg;
    cau_side_t          d_side_reg;

    logic [63:0]   rem_re_next, rem_im_next;
    logic [QW-1:0] nlow_re_next, nlow_im_next;
    cau_side_t     side_next;

    always_comb begin
        logic [NW-1:0] n_re, n_im;
        logic [HW-1:0] h_re, h_im;
        sat_t          mr, mi;
        n_re = NW'(c_mag_re_reg) << FRAC_BITS;
        n_im = NW'(c_mag_im_reg) << FRAC_BITS;
        h_re = n_re[NW-1:QW];
        h_im = n_im[NW-1:QW];
        rem_re_next  = 64'(h_re);
        rem_im_next  = 64'(h_im);
        nlow_re_next = n_re[QW-1:0];
        nlow_im_next = n_im[QW-1:0];
        mr = sat65(c_msum_re_reg);
        mi = sat65(c_msum_im_reg);
        side_next.is_div  = (c_cmd_reg == CMD_DIV);
        side_next.dz      = c_dz_reg;
        side_next.eq      = c_eq_reg;
        side_next.pre_re  = (c_cmd_reg == CMD_MUL) ? mr.val : c_simp_re_reg;
        side_next.pre_im  = (c_cmd_reg == CMD_MUL) ? mi.val : c_simp_im_reg;
        side_next.pre_ov  = (c_cmd_reg == CMD_MUL) ? (mr.ov || mi.ov) : c_simp_ov_reg;
        side_next.neg_re  = c_neg_re_reg;
        side_next.neg_im  = c_neg_im_reg;
        side_next.qovf_re = 64'(h_re) >= c_den_reg;
        side_next.qovf_im = 64'(h_im) >= c_den_reg;
    end

    // Output stage.
    logic        m_valid_reg;
    logic [31:0] res_re_reg, res_im_reg;
    logic        eq_reg, dz_reg, ov_reg;

    logic [31:0] res_re_next, res_im_next;
    logic        eq_out_next, dz_next, ov_next;

    always_comb begin
        sat_t lr, li;
        lr = div_lane(div_q_re, div_side.neg_re, div_side.qovf_re);
        li = div_lane(div_q_im, div_side.neg_im, div_side.qovf_im);
        eq_out_next = div_side.eq;
        dz_next     = 1'b0;
        if (!div_side.is_div) begin
            res_re_next = div_side.pre_re;
            res_im_next = div_side.pre_im;
            ov_next     = div_side.pre_ov;
        end else if (div_side.dz) begin
            res_re_next = '0;
            res_im_next = '0;
            ov_next     = 1'b0;
            dz_next     = 1'b1;
        end else begin
            res_re_next = lr.val;
            res_im_next = li.val;
            ov_next     = lr.ov || li.ov;
        end
    end

    assign e_rdy   = !m_valid_reg || m_ready;
    assign d_rdy   = !d_v_reg || div_in_ready;
    assign c_rdy   = !c_v_reg || d_rdy;
    assign b_rdy   = !b_v_reg || c_rdy;
    assign a_rdy   = !a_v_reg || b_rdy;
    assign s_ready = a_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg     <= 1'b0;
            b_v_reg     <= 1'b0;
            c_v_reg     <= 1'b0;
            d_v_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_rdy) begin
                a_v_reg <= s_valid;
            end
            if (b_rdy) begin
                b_v_reg <= a_v_reg;
            end
            if (c_rdy) begin
                c_v_reg <= b_v_reg;
            end
            if (d_rdy) begin
                d_v_reg <= c_v_reg;
            end
            if (e_rdy) begin
                m_valid_reg <= div_out_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && s_valid) begin
            a_cmd_reg     <= s_command;
            a_arbr_reg    <= s_a_real * s_b_real;
            a_aibi_reg    <= s_a_imag * s_b_imag;
            a_arbi_reg    <= s_a_real * s_b_imag;
            a_aibr_reg    <= s_a_imag * s_b_real;
            a_brbr_reg    <= s_b_real * s_b_real;
            a_bibi_reg    <= s_b_imag * s_b_imag;
            a_simp_re_reg <= simp_re_next;
            a_simp_im_reg <= simp_im_next;
            a_simp_ov_reg <= simp_ov_next;
            a_eq_reg      <= eq_next;
            a_dz_reg      <= (s_b_real == 32'sd0) && (s_b_imag == 32'sd0);
        end
        if (b_rdy && a_v_reg) begin
            b_cmd_reg     <= a_cmd_reg;
            b_tarbr_reg   <= trunc_prod(a_arbr_reg);
            b_taibi_reg   <= trunc_prod(a_aibi_reg);
            b_tarbi_reg   <= trunc_prod(a_arbi_reg);
            b_taibr_reg   <= trunc_prod(a_aibr_reg);
            b_num_re_reg  <= {a_arbr_reg[63], a_arbr_reg} + {a_aibi_reg[63], a_aibi_reg};
            b_num_im_reg  <= {a_aibr_reg[63], a_aibr_reg} - {a_arbi_reg[63], a_arbi_reg};
            b_den_reg     <= $unsigned(a_brbr_reg) + $unsigned(a_bibi_reg);
            b_simp_re_reg <= a_simp_re_reg;
            b_simp_im_reg <= a_simp_im_reg;
            b_simp_ov_reg <= a_simp_ov_reg;
            b_eq_reg      <= a_eq_reg;
            b_dz_reg      <= a_dz_reg;
        end
        if (c_rdy && b_v_reg) begin
            c_cmd_reg     <= b_cmd_reg;
            c_msum_re_reg <= {b_tarbr_reg[63], b_tarbr_reg} - {b_taibi_reg[63], b_taibi_reg};
            c_msum_im_reg <= {b_tarbi_reg[63], b_tarbi_reg} + {b_taibr_reg[63], b_taibr_reg};
            c_neg_re_reg  <= b_num_re_reg[64];
            c_neg_im_reg  <= b_num_im_reg[64];
            c_mag_re_reg  <= b_num_re_reg[64] ? 64'(-b_num_re_reg) : b_num_re_reg[63:0];
            c_mag_im_reg  <= b_num_im_reg[64] ? 64'(-b_num_im_reg) : b_num_im_reg[63:0];
            c_den_reg     <= b_den_reg;
            c_simp_re_reg <= b_simp_re_reg;
            c_simp_im_reg <= b_simp_im_reg;
            c_simp_ov_reg <= b_simp_ov_reg;
            c_eq_reg      <= b_eq_reg;
            c_dz_reg      <= b_dz_reg;
        end
        if (d_rdy && c_v_reg) begin
            d_den_reg     <= c_den_reg;
            d_rem_re_reg  <= rem_re_next;
            d_rem_im_reg  <= rem_im_next;
            d_nlow_re_reg <= nlow_re_next;
            d_nlow_im_reg <= nlow_im_next;
            d_side_reg    <= side_next;
        end
        if (e_rdy && div_out_valid) begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            eq_reg     <= eq_out_next;
            dz_reg     <= dz_next;
            ov_reg     <= ov_next;
        end
    end

    cau_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (d_v_reg),
        .in_ready   (div_in_ready),
        .in_den     (d_den_reg),
        .in_rem_re  (d_rem_re_reg),
        .in_rem_im  (d_rem_im_reg),
        .in_nlow_re (d_nlow_re_reg),
        .in_nlow_im (d_nlow_im_reg),
        .in_side    (d_side_reg),
        .out_valid  (div_out_valid),
        .out_ready  (e_rdy),
        .out_q_re   (div_q_re),
        .out_q_im   (div_q_im),
        .out_side   (div_side)
    );

    assign m_valid    = m_valid_reg;
    assign m_res_real = res_re_reg;
    assign m_res_imag = res_im_reg;
    assign m_is_equal = eq_reg;
    assign m_div_zero = dz_reg;
    assign m_overflow = ov_reg;

endmodule
